[src/rfw_pkg.sv]
// shared constants and types for the range fold and wrap unit
package rfw_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FOLD_OR_WRAP = 2'd0,
      CSR_BOUND_A      = 2'd1,
      CSR_BOUND_B      = 2'd2
   } csr_index_type;

   // how the last stage forms the result from the remainder
   typedef enum logic [2:0] {
      SEL_PASS,
      SEL_MIN,
      SEL_LO_PLUS,
      SEL_HI_MINUS_WRAP,
      SEL_FOLD_BELOW,
      SEL_FOLD_ABOVE
   } sel_type;

   typedef struct packed {
      sel_type sel;
      logic    q_odd;
   } ctl_type;

endpackage

[src/rfw_if.sv]
// request and response stream interfaces of the range fold and wrap unit
interface rfw_req_if #(parameter int W = rfw_pkg::DATA_WIDTH);
   logic         valid;
   logic         ready;
   logic [W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface rfw_rsp_if #(parameter int W = rfw_pkg::DATA_WIDTH);
   logic         valid;
   logic         ready;
   logic [W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

[src/rfw_prep.sv]
// first stage: range test, case selection and dividend setup
module rfw_prep #(
   parameter int W = rfw_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [W-1:0]     sample,
   input  logic             fold_or_wrap,
   input  logic [W-1:0]     lo,
   input  logic [W-1:0]     hi,
   input  logic [W-1:0]     span,
   output logic             out_valid,
   input  logic             out_ready,
   output rfw_pkg::ctl_type ctl,
   output logic [W-1:0]     x_out,
   output logic [W-1:0]     dvd_out
);

   logic             valid_ff;
   rfw_pkg::ctl_type ctl_ff, ctl_in;
   logic [W-1:0]     x_ff;
   logic [W-1:0]     dvd_ff, dvd_in;
   logic             below, above;
   logic [W:0]       x_minus_lo, lo_minus_x, x_minus_hi;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      below      = $signed(sample) < $signed(lo);
      above      = $signed(sample) > $signed(hi);
      x_minus_lo = {sample[W-1], sample} - {lo[W-1], lo};
      lo_minus_x = {lo[W-1], lo} - {sample[W-1], sample};
      x_minus_hi = {sample[W-1], sample} - {hi[W-1], hi};
      ctl_in.q_odd = 1'b0;
      priority if (!below && !above) begin
         ctl_in.sel = rfw_pkg::SEL_PASS;
         dvd_in     = '0;
      end else if (span == '0) begin
         ctl_in.sel = rfw_pkg::SEL_MIN;
         dvd_in     = '0;
      end else if (fold_or_wrap && above) begin
         ctl_in.sel = rfw_pkg::SEL_LO_PLUS;
         dvd_in     = x_minus_lo[W-1:0];
      end else if (fold_or_wrap) begin
         ctl_in.sel = rfw_pkg::SEL_HI_MINUS_WRAP;
         dvd_in     = lo_minus_x[W-1:0];
      end else if (below) begin
         ctl_in.sel = rfw_pkg::SEL_FOLD_BELOW;
         dvd_in     = lo_minus_x[W-1:0];
      end else begin
         ctl_in.sel = rfw_pkg::SEL_FOLD_ABOVE;
         dvd_in     = x_minus_hi[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctl_ff <= ctl_in;
         x_ff   <= sample;
         dvd_ff <= dvd_in;
      end
   end

   assign out_valid = valid_ff;
   assign ctl       = ctl_ff;
   assign x_out     = x_ff;
   assign dvd_out   = dvd_ff;

endmodule

[src/rfw_div_step.sv]
// one restoring division stage: one quotient bit per stage
module rfw_div_step #(
   parameter int W = rfw_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rfw_pkg::ctl_type in_ctl,
   input  logic [W-1:0]     in_x,
   input  logic [W-1:0]     in_dvd,
   input  logic [W-1:0]     in_rem,
   input  logic [W-1:0]     span,
   output logic             out_valid,
   input  logic             out_ready,
   output rfw_pkg::ctl_type out_ctl,
   output logic [W-1:0]     out_x,
   output logic [W-1:0]     out_dvd,
   output logic [W-1:0]     out_rem
);

   logic             valid_ff;
   rfw_pkg::ctl_type ctl_ff, ctl_in;
   logic [W-1:0]     x_ff;
   logic [W-1:0]     dvd_ff;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W:0]       trial, diff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial = {in_rem, in_dvd[W-1]};
      diff  = trial - {1'b0, span};
      ctl_in = in_ctl;
      if (trial >= {1'b0, span}) begin
         rem_in       = diff[W-1:0];
         ctl_in.q_odd = 1'b1;
      end else begin
         rem_in       = trial[W-1:0];
         ctl_in.q_odd = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctl_ff <= ctl_in;
         x_ff   <= in_x;
         dvd_ff <= {in_dvd[W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_dvd   = dvd_ff;
   assign out_rem   = rem_ff;

endmodule

[src/rfw_finish.sv]
// last stage: result from remainder and quotient parity, output register
module rfw_finish #(
   parameter int W = rfw_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rfw_pkg::ctl_type in_ctl,
   input  logic [W-1:0]     in_x,
   input  logic [W-1:0]     in_rem,
   input  logic [W-1:0]     lo,
   input  logic [W-1:0]     hi,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [W-1:0]     out_sample
);

   logic         valid_ff;
   logic [W-1:0] sample_ff, sample_in;
   logic [W-1:0] lo_plus, hi_minus;

   assign in_ready = !valid_ff || out_ready;

   // results lie between the bounds, so W-bit wraparound is exact
   always_comb begin
      lo_plus  = lo + in_rem;
      hi_minus = hi - in_rem;
      unique case (in_ctl.sel)
         rfw_pkg::SEL_PASS:          sample_in = in_x;
         rfw_pkg::SEL_MIN:           sample_in = lo;
         rfw_pkg::SEL_LO_PLUS:       sample_in = lo_plus;
         rfw_pkg::SEL_HI_MINUS_WRAP: sample_in = (in_rem == '0) ? lo : hi_minus;
         rfw_pkg::SEL_FOLD_BELOW:    sample_in = in_ctl.q_odd ? hi_minus : lo_plus;
         rfw_pkg::SEL_FOLD_ABOVE:    sample_in = in_ctl.q_odd ? lo_plus : hi_minus;
         default:                    sample_in = lo;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

[src/range_fold_wrap_unit.sv]
// Range fold and wrap unit: brings each signed fixed-point request into the
// range between two configured bounds, folding or wrapping what lies outside.
// Channels: requests arrive on req_if (valid/ready, sample_in), results leave
// on rsp_if (valid/ready, sample_out), one result per request, in order.
// Configuration: csr_we writes csr_wdata to register csr_index (fold_or_wrap,
// bound_a, bound_b); the bounds may be given in either order. Write only
// while no request is in flight.
// Pipeline: the setup stage loads at the accept edge, then one restoring
// division stage per dividend bit and one output stage follow.
// Throughput: one request per cycle while rsp_if.ready stays high; every stage holds one request.
// Stall: when rsp_if.ready is low, the output holds and back-pressure ripples
// back stage by stage; empty stages keep filling, so bubbles are absorbed and
// nothing is lost or repeated.
// Reset: pipeline emptied, fold mode selected, both bounds cleared to zero.
module range_fold_wrap_unit #(
   parameter int DATA_WIDTH = rfw_pkg::DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   rfw_req_if.sink                             req_if,
   rfw_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [rfw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]               csr_wdata
);

   localparam int W = DATA_WIDTH;

   logic         fold_or_wrap_ff;
   logic [W-1:0] bound_a_ff;
   logic [W-1:0] bound_b_ff;
   logic [W-1:0] lo, hi, span;

   logic             valid_s [0:W];
   logic             ready_s [0:W];
   rfw_pkg::ctl_type ctl_s   [0:W];
   logic [W-1:0]     x_s     [0:W];
   logic [W-1:0]     dvd_s   [0:W];
   logic [W-1:0]     rem_s   [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_or_wrap_ff <= 1'b0;
         bound_a_ff      <= '0;
         bound_b_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rfw_pkg::CSR_FOLD_OR_WRAP: fold_or_wrap_ff <= csr_wdata[0];
            rfw_pkg::CSR_BOUND_A:      bound_a_ff      <= csr_wdata;
            rfw_pkg::CSR_BOUND_B:      bound_b_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ordered bounds; span always fits W bits unsigned
   always_comb begin
      if ($signed(bound_a_ff) < $signed(bound_b_ff)) begin
         lo = bound_a_ff;
         hi = bound_b_ff;
      end else begin
         lo = bound_b_ff;
         hi = bound_a_ff;
      end
      span = hi - lo;
   end

   rfw_prep #(.W(W)) u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .sample       (req_if.sample_in),
      .fold_or_wrap (fold_or_wrap_ff),
      .lo           (lo),
      .hi           (hi),
      .span         (span),
      .out_valid    (valid_s[0]),
      .out_ready    (ready_s[0]),
      .ctl          (ctl_s[0]),
      .x_out        (x_s[0]),
      .dvd_out      (dvd_s[0])
   );

   assign rem_s[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_div
      rfw_div_step #(.W(W)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[k]),
         .in_ready  (ready_s[k]),
         .in_ctl    (ctl_s[k]),
         .in_x      (x_s[k]),
         .in_dvd    (dvd_s[k]),
         .in_rem    (rem_s[k]),
         .span      (span),
         .out_valid (valid_s[k+1]),
         .out_ready (ready_s[k+1]),
         .out_ctl   (ctl_s[k+1]),
         .out_x     (x_s[k+1]),
         .out_dvd   (dvd_s[k+1]),
         .out_rem   (rem_s[k+1])
      );
   end

   rfw_finish #(.W(W)) u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_s[W]),
      .in_ready   (ready_s[W]),
      .in_ctl     (ctl_s[W]),
      .in_x       (x_s[W]),
      .in_rem     (rem_s[W]),
      .lo         (lo),
      .hi         (hi),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_sample (rsp_if.sample_out)
   );

endmodule

[tb/range_fold_wrap_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the range fold and wrap unit
module range_fold_wrap_unit_test;

   localparam int W = rfw_pkg::DATA_WIDTH;
   localparam int IW = rfw_pkg::CSR_INDEX_WIDTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = rfw_pkg::DATA_WIDTH + 8;
   localparam int ITEMS_PER_SETTING = 20;
   localparam logic FOLD_MODE = 1'b0;
   localparam logic WRAP_MODE = 1'b1;
   localparam logic [IW-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [W-1:0] MOST_NEGATIVE = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;
   localparam longint ONE = longint'(1) << 16;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IW-1:0] csr_index;
   logic [W-1:0] csr_wdata;

   rfw_req_if req_ch();
   rfw_rsp_if rsp_ch();

   range_fold_wrap_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the register file
   logic         wrap_cfg;
   logic [W-1:0] bound_a_cfg;
   logic [W-1:0] bound_b_cfg;

   logic [W-1:0] expected_samples[$];
   int           mismatch_count;
   int           send_idle_pct;
   int           stall_pct;
   int           cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_samples.size());
         $display("FAIL range_fold_wrap_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      logic [W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time,
                     rsp_ch.sample_out);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_ch.sample_out !== want) begin
               $display("%0t sample_out mismatch: expected %h, actual %h", $time, want,
                        rsp_ch.sample_out);
               mismatch_count++;
            end
         end
      end
   end

   // value brought into [min(a,b), max(a,b)] by folding or wrapping
   function automatic logic [W-1:0] fold_wrap_value(input logic [W-1:0] sample,
                                                    input logic [W-1:0] bound_x,
                                                    input logic [W-1:0] bound_y,
                                                    input logic wrap);
      longint x, lo, hi, span, gap, quot, rem;
      x  = longint'($signed(sample));
      lo = longint'($signed(bound_x));
      hi = longint'($signed(bound_y));
      if (lo > hi) begin
         gap = lo;
         lo  = hi;
         hi  = gap;
      end
      if (x >= lo && x <= hi) return sample;
      span = hi - lo;
      if (span == 0) return lo[W-1:0];
      if (wrap) begin
         if (x > hi) return W'(lo + (x - lo) % span);
         rem = (lo - x) % span;
         return (rem == 0) ? W'(lo) : W'(hi - rem);
      end
      if (x < lo) begin
         gap  = lo - x;
         quot = gap / span;
         rem  = gap % span;
         return quot[0] ? W'(hi - rem) : W'(lo + rem);
      end
      gap  = x - hi;
      quot = gap / span;
      rem  = gap % span;
      return quot[0] ? W'(lo + rem) : W'(hi - rem);
   endfunction

   // random values, values in range, values near the bounds or whole multiples of the span away from them, and extremes
   function automatic logic [W-1:0] pick_sample();
      longint lo, hi, span, k, off;
      lo = longint'($signed(bound_a_cfg));
      hi = longint'($signed(bound_b_cfg));
      if (lo > hi) begin
         span = lo;
         lo   = hi;
         hi   = span;
      end
      span = hi - lo;
      k    = $urandom_range(0, 6);
      off  = longint'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 4))
         0: return W'($urandom);
         1: return W'(lo + longint'($urandom) % (span + 1));
         2: return W'(lo - k * span - off);
         3: return W'(hi + k * span + off);
         default: begin
            case ($urandom_range(0, 3))
               0: return MOST_NEGATIVE;
               1: return MOST_POSITIVE;
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic send_sample(input logic [W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_samples.push_back(fold_wrap_value(value, bound_a_cfg, bound_b_cfg, wrap_cfg));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [IW-1:0] index,
                                 input logic [W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         rfw_pkg::CSR_FOLD_OR_WRAP: wrap_cfg    = data[0];
         rfw_pkg::CSR_BOUND_A:      bound_a_cfg = data;
         rfw_pkg::CSR_BOUND_B:      bound_b_cfg = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic wrap, input logic [W-1:0] bound_x,
                            input logic [W-1:0] bound_y, input logic [W-2:0] upper_bits);
      write_register(rfw_pkg::CSR_FOLD_OR_WRAP, {upper_bits, wrap});
      write_register(rfw_pkg::CSR_BOUND_A, bound_x);
      write_register(rfw_pkg::CSR_BOUND_B, bound_y);
   endtask

   // both bounds zero after reset
   task automatic test_reset_state();
      send_sample('0);
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      wait_idle();
   endtask

   task automatic test_fold_directed();
      configure(FOLD_MODE, W'(-ONE), W'(3 * ONE), '0);
      send_sample(W'(-ONE));
      send_sample(W'(3 * ONE));
      send_sample(W'(3 * ONE / 2));
      send_sample(W'(4 * ONE));
      send_sample(W'(8 * ONE));
      send_sample(W'(-7 * ONE / 2));
      send_sample(W'(-6 * ONE));
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      wait_idle();
   endtask

   task automatic test_wrap_directed();
      configure(WRAP_MODE, W'(-ONE), W'(3 * ONE), '0);
      send_sample(W'(11 * ONE));
      send_sample(W'(-9 * ONE));
      send_sample(W'(9 * ONE / 2));
      send_sample(W'(-2 * ONE));
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      wait_idle();
   endtask

   task automatic test_bound_corner_cases();
      configure(FOLD_MODE, W'(3 * ONE), W'(-ONE), '0);
      send_sample(W'(5 * ONE));
      wait_idle();
      configure(WRAP_MODE, W'(3 * ONE), W'(-ONE), '0);
      send_sample(W'(-2 * ONE));
      wait_idle();
      // zero-width range, with every unused bit of the mode word set
      configure(FOLD_MODE, W'(2 * ONE), W'(2 * ONE), '1);
      write_register(CSR_UNUSED_INDEX, W'($urandom));
      send_sample(W'(2 * ONE));
      send_sample(W'(9 * ONE));
      send_sample(W'(-9 * ONE));
      wait_idle();
      configure(WRAP_MODE, MOST_NEGATIVE, MOST_POSITIVE, '0);
      send_sample(W'($urandom));
      wait_idle();
      configure(FOLD_MODE, MOST_NEGATIVE, W'(MOST_NEGATIVE + 1), '0);
      send_sample(MOST_POSITIVE);
      wait_idle();
   endtask

   task automatic run_random_items(input int idle_pct, input int stall, input int item_count);
      logic [W-1:0] base, span, bound_x, bound_y;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int sent = 0; sent < item_count; sent++) begin
         if (sent % ITEMS_PER_SETTING == 0) begin
            wait_idle();
            base = W'($urandom);
            case ($urandom_range(0, 5))
               0: span = W'($urandom_range(1, 64));
               1: span = W'($urandom_range(1, 1 << 20));
               2: span = W'($urandom);
               3: span = '0;
               4: begin
                  base = MOST_NEGATIVE;
                  span = W'($urandom);
               end
               default: span = MOST_POSITIVE - base;
            endcase
            bound_x = base;
            bound_y = base + span;
            if ($urandom_range(0, 1))
               configure(1'($urandom_range(0, 1)), bound_x, bound_y, (W-1)'($urandom));
            else
               configure(1'($urandom_range(0, 1)), bound_y, bound_x, (W-1)'($urandom));
         end
         send_sample(pick_sample());
      end
      wait_idle();
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      csr_we           <= 1'b0;
      csr_index        <= rfw_pkg::CSR_FOLD_OR_WRAP;
      csr_wdata        <= '0;
      wrap_cfg         = FOLD_MODE;
      bound_a_cfg      = '0;
      bound_b_cfg      = '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_fold_directed();
      test_wrap_directed();
      test_bound_corner_cases();
      run_random_items(0, 0, 100);
      run_random_items(49, 0, 100);
      run_random_items(0, 49, 100);
      run_random_items(33, 33, 100);

      // anything arriving now has no request behind it
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS range_fold_wrap_unit");
      else
         $display("FAIL range_fold_wrap_unit");
      $finish;
   end

endmodule
